// ===== rtl/hash_set_sorted_buckets_macros.svh =====
// assertion macros shared by the hash set rtl
`ifndef HASH_SET_SORTED_BUCKETS_MACROS_SVH
`define HASH_SET_SORTED_BUCKETS_MACROS_SVH

// implication checked on every clock edge outside reset
`define HSSB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define HSSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hssb_pkg.sv =====
`timescale 1ns / 1ps
package hssb_pkg;

  localparam logic [8:0] BUCKET_COUNT_RESET = 9'd193;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FRD, S_FWT, S_SRD, S_SCMP, S_DEC,
    S_MRD, S_MWR, S_PUT, S_FUPD, S_CLR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] total_entries;
  } out_t;

endpackage

// ===== rtl/hash_set_sorted_buckets.sv =====
`timescale 1ns / 1ps
// Set of 64-bit values in BUCKETS buckets of up to SLOTS sorted values each; the bucket is
// the value modulo bucket_count (0 acts as 1, values above BUCKETS saturate). Values and
// fill counts sit in two single-port RAMs with registered read data. One transaction is
// handled at a time: insert, find or remove first runs the value through the 4-bit-per-cycle
// remainder unit, then reads the fill count and scans the slots up to the sorted position;
// insert and remove then shift values one by one over the serial RAM port. Clear writes
// one fill entry per cycle. After reset the same pass zeroes the fill RAM before the first
// transaction is accepted. A result waits in an output register while the next transaction
// is taken.
`include "hash_set_sorted_buckets_macros.svh"
module hash_set_sorted_buckets #(
  parameter int BUCKETS = 256,
  parameter int SLOTS   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [8:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  hssb_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hssb_pkg::out_t   out_data
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int DEPTH = BUCKETS * SLOTS;
  localparam int VAW   = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);

  hssb_pkg::state_t  state, state_next;
  hssb_pkg::op_t     op, op_next;
  hssb_pkg::status_t st, st_next;
  logic [63:0]    val, val_next, dsh, dsh_next;
  logic [8:0]     rem, rem_next, nb, nb_next, bcount;
  logic [3:0]     dcnt, dcnt_next;
  logic [BW-1:0]  bucket, bucket_next, ccnt, ccnt_next;
  logic [VAW-1:0] base, base_next;
  logic [FW-1:0]  fill, fill_next, idx, idx_next, pos, pos_next;
  logic           hit, hit_next, creport, creport_next;
  logic [TW-1:0]  total, total_next;
  logic           ovalid_next;
  hssb_pkg::out_t odata_next;

  // value and fill memories
  logic [63:0]    va_mem [DEPTH];
  logic [VAW-1:0] va_addr;
  logic           va_we;
  logic [63:0]    va_wd, va_rdata;
  logic [FW-1:0]  f_mem [BUCKETS];
  logic [BW-1:0]  f_addr;
  logic           f_we;
  logic [FW-1:0]  f_wd, f_rdata;

  always_ff @(posedge clk) begin
    if (va_we) begin
      va_mem[va_addr] <= va_wd;
    end
    va_rdata <= va_mem[va_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      f_mem[f_addr] <= f_wd;
    end
    f_rdata <= f_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcount <= hssb_pkg::BUCKET_COUNT_RESET;
    end else if (cfg_we) begin
      bcount <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hssb_pkg::S_CLR;
      ccnt      <= '0;
      creport   <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ccnt      <= ccnt_next;
      creport   <= creport_next;
      total     <= total_next;
      out_valid <= ovalid_next;
    end
    op       <= op_next;
    st       <= st_next;
    val      <= val_next;
    dsh      <= dsh_next;
    rem      <= rem_next;
    nb       <= nb_next;
    dcnt     <= dcnt_next;
    bucket   <= bucket_next;
    base     <= base_next;
    fill     <= fill_next;
    idx      <= idx_next;
    pos      <= pos_next;
    hit      <= hit_next;
    out_data <= odata_next;
  end

  assign in_ready = (state == hssb_pkg::S_IDLE);

  always_comb begin
    logic [9:0] t;
    logic [8:0] r;
    state_next   = state;
    op_next      = op;
    st_next      = st;
    val_next     = val;
    dsh_next     = dsh;
    rem_next     = rem;
    nb_next      = nb;
    dcnt_next    = dcnt;
    bucket_next  = bucket;
    base_next    = base;
    fill_next    = fill;
    idx_next     = idx;
    pos_next     = pos;
    hit_next     = hit;
    ccnt_next    = ccnt;
    creport_next = creport;
    total_next   = total;
    ovalid_next  = out_valid && !out_ready;
    odata_next   = out_data;
    va_addr      = base + VAW'(idx);
    va_we        = 1'b0;
    va_wd        = va_rdata;
    f_addr       = bucket;
    f_we         = 1'b0;
    f_wd         = '0;
    t            = '0;
    r            = rem;

    unique case (state)
      hssb_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next   = hssb_pkg::op_t'(in_data.operation);
          val_next  = in_data.value;
          dsh_next  = in_data.value;
          rem_next  = '0;
          dcnt_next = '0;
          if (bcount == 9'd0) begin
            nb_next = 9'd1;
          end else if (32'(bcount) > BUCKETS) begin
            nb_next = 9'(BUCKETS);
          end else begin
            nb_next = bcount;
          end
          if (in_data.operation == hssb_pkg::OP_CLEAR) begin
            ccnt_next    = '0;
            creport_next = 1'b1;
            state_next   = hssb_pkg::S_CLR;
          end else begin
            state_next = hssb_pkg::S_DIV;
          end
        end
      end
      hssb_pkg::S_DIV: begin
        // restoring remainder, four quotient bits per cycle
        for (int k = 0; k < 4; k++) begin
          t = {r, dsh[63 - k]};
          if (t >= {1'b0, nb}) begin
            t = t - {1'b0, nb};
          end
          r = t[8:0];
        end
        rem_next  = r;
        dsh_next  = {dsh[59:0], 4'b0};
        dcnt_next = dcnt + 4'd1;
        if (dcnt == 4'd15) begin
          bucket_next = BW'(r);
          base_next   = VAW'(BW'(r)) * VAW'(SLOTS);
          state_next  = hssb_pkg::S_FRD;
        end
      end
      hssb_pkg::S_FRD: begin
        state_next = hssb_pkg::S_FWT;
      end
      hssb_pkg::S_FWT: begin
        fill_next  = f_rdata;
        idx_next   = '0;
        state_next = hssb_pkg::S_SRD;
      end
      hssb_pkg::S_SRD: begin
        if (idx == fill) begin
          pos_next   = idx;
          hit_next   = 1'b0;
          state_next = hssb_pkg::S_DEC;
        end else begin
          state_next = hssb_pkg::S_SCMP;
        end
      end
      hssb_pkg::S_SCMP: begin
        if (va_rdata < val) begin
          idx_next   = idx + FW'(1);
          state_next = hssb_pkg::S_SRD;
        end else begin
          pos_next   = idx;
          hit_next   = (va_rdata == val);
          state_next = hssb_pkg::S_DEC;
        end
      end
      hssb_pkg::S_DEC: begin
        state_next = hssb_pkg::S_DONE;
        case (op)
          hssb_pkg::OP_INSERT: begin
            if (hit) begin
              st_next = hssb_pkg::ST_PRESENT;
            end else if (fill == FW'(SLOTS)) begin
              st_next = hssb_pkg::ST_FULL;
            end else begin
              idx_next   = fill;
              state_next = (fill == pos) ? hssb_pkg::S_PUT : hssb_pkg::S_MRD;
            end
          end
          hssb_pkg::OP_REMOVE: begin
            if (!hit) begin
              st_next = hssb_pkg::ST_NOT_FOUND;
            end else begin
              idx_next   = pos;
              state_next = (pos + FW'(1) == fill) ? hssb_pkg::S_FUPD : hssb_pkg::S_MRD;
            end
          end
          default: begin
            st_next = hit ? hssb_pkg::ST_FOUND : hssb_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      hssb_pkg::S_MRD: begin
        // fetch the neighbor that moves into slot idx
        if (op == hssb_pkg::OP_INSERT) begin
          va_addr = base + VAW'(idx - FW'(1));
        end else begin
          va_addr = base + VAW'(idx + FW'(1));
        end
        state_next = hssb_pkg::S_MWR;
      end
      hssb_pkg::S_MWR: begin
        va_we = 1'b1;
        if (op == hssb_pkg::OP_INSERT) begin
          idx_next   = idx - FW'(1);
          state_next = (idx - FW'(1) == pos) ? hssb_pkg::S_PUT : hssb_pkg::S_MRD;
        end else begin
          idx_next   = idx + FW'(1);
          state_next = (idx + FW'(2) == fill) ? hssb_pkg::S_FUPD : hssb_pkg::S_MRD;
        end
      end
      hssb_pkg::S_PUT: begin
        va_addr    = base + VAW'(pos);
        va_we      = 1'b1;
        va_wd      = val;
        state_next = hssb_pkg::S_FUPD;
      end
      hssb_pkg::S_FUPD: begin
        f_we = 1'b1;
        if (op == hssb_pkg::OP_INSERT) begin
          f_wd       = fill + FW'(1);
          total_next = total + TW'(1);
          st_next    = hssb_pkg::ST_ADDED;
        end else begin
          f_wd = fill - FW'(1);
          if (total != '0) begin
            total_next = total - TW'(1);
          end
          st_next = hssb_pkg::ST_REMOVED;
        end
        state_next = hssb_pkg::S_DONE;
      end
      hssb_pkg::S_CLR: begin
        f_addr     = ccnt;
        f_we       = 1'b1;
        f_wd       = '0;
        ccnt_next  = ccnt + BW'(1);
        total_next = '0;
        if (ccnt == BW'(BUCKETS - 1)) begin
          st_next    = hssb_pkg::ST_CLEARED;
          state_next = creport ? hssb_pkg::S_DONE : hssb_pkg::S_IDLE;
        end
      end
      hssb_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          ovalid_next              = 1'b1;
          odata_next.status        = st;
          odata_next.total_entries = 12'(total);
          creport_next             = 1'b0;
          state_next               = hssb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hssb_pkg::S_IDLE;
      end
    endcase
  end

  `HSSB_ASSERT_IMPL(a_fill_range, clk, rst, state == hssb_pkg::S_FWT, f_rdata <= FW'(SLOTS), "fill count above slot count")
  `HSSB_ASSERT_IMPL(a_pos_range, clk, rst, state == hssb_pkg::S_DEC, pos <= fill, "sorted position beyond fill")
  `HSSB_ASSERT_IMPL(a_clear_total, clk, rst, state == hssb_pkg::S_DONE && st == hssb_pkg::ST_CLEARED, total == '0, "total not zero after clear")
  `HSSB_ASSERT_NEXT(a_done_result, clk, rst, state == hssb_pkg::S_DONE && (!out_valid || out_ready), out_valid && state == hssb_pkg::S_IDLE, "result not posted")

endmodule
